// ----- design/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros used by the top-level design file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

// ----- design/tsg_pkg.sv -----
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared constants, width helpers and types of the tetrahedron gradient block.
// ----------------------------------------------------------------------------
package tsg_pkg;

	localparam int COORD_WIDTH_DEF = 16;
	localparam int GRAD_W          = 32;
	localparam int JAC_W           = 52;
	localparam int NODE_W          = 2;
	localparam int FRAC_SHIFT      = 24;
	localparam int QDEPTH          = 2;
	localparam logic [NODE_W-1:0] NODE_LAST = 2'd3;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_OUT
	} bk_state_t;

	// Width of one cofactor (difference of edge products, a*b - c*d).
	function automatic int cof_w(input int cw);
		return 2 * cw + 3;
	endfunction

	// Width of one gradient numerator (node 0 sums three cofactors).
	function automatic int gval_w(input int cw);
		return 2 * cw + 5;
	endfunction

	// Width of the internal determinant, kept modulo 2^64 at most.
	function automatic int jint_w(input int cw);
		return (3 * cw + 6 > 64) ? 64 : 3 * cw + 6;
	endfunction

	// One queue entry: nine cofactors, three node 0 sums, the determinant.
	function automatic int entry_w(input int cw);
		return 12 * gval_w(cw) + jint_w(cw);
	endfunction

endpackage

// ----- design/tsg_front.sv -----
// ----------------------------------------------------------------------------
// tsg_front
// Four-stage pipeline: edge vectors, cofactors, determinant terms, determinant.
// ----------------------------------------------------------------------------
module tsg_front #(
	parameter int COORD_WIDTH = tsg_pkg::COORD_WIDTH_DEF,
	localparam int EW = tsg_pkg::entry_w(COORD_WIDTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_WIDTH-1:0] x0,
	input  logic signed [COORD_WIDTH-1:0] x1,
	input  logic signed [COORD_WIDTH-1:0] x2,
	input  logic signed [COORD_WIDTH-1:0] x3,
	input  logic signed [COORD_WIDTH-1:0] y0,
	input  logic signed [COORD_WIDTH-1:0] y1,
	input  logic signed [COORD_WIDTH-1:0] y2,
	input  logic signed [COORD_WIDTH-1:0] y3,
	input  logic signed [COORD_WIDTH-1:0] z0,
	input  logic signed [COORD_WIDTH-1:0] z1,
	input  logic signed [COORD_WIDTH-1:0] z2,
	input  logic signed [COORD_WIDTH-1:0] z3,
	output logic                          q_valid,
	input  logic                          q_ready,
	output logic [EW-1:0]                 q_data
);
	import tsg_pkg::*;

	localparam int EDW = COORD_WIDTH + 1;
	localparam int CFW = cof_w(COORD_WIDTH);
	localparam int GW  = gval_w(COORD_WIDTH);
	localparam int JW  = jint_w(COORD_WIDTH);
	localparam int PW  = EDW + CFW;

	function automatic logic signed [CFW-1:0] cross2(
		input logic signed [EDW-1:0] a,
		input logic signed [EDW-1:0] b,
		input logic signed [EDW-1:0] c,
		input logic signed [EDW-1:0] d
	);
		logic signed [2*EDW-1:0] p;
		logic signed [2*EDW-1:0] r;
		p = a * b;
		r = c * d;
		return CFW'(p) - CFW'(r);
	endfunction

	logic signed [COORD_WIDTH-1:0] pt [3][4];
	logic signed [EDW-1:0] e_s1 [3][3];
	logic signed [EDW-1:0] e1_s2 [3];
	logic signed [CFW-1:0] cof_s2 [3][3];
	logic signed [CFW-1:0] cof_s3 [3][3];
	logic signed [CFW-1:0] cof_s4 [3][3];
	logic signed [CFW-1:0] cof_c [3][3];
	logic signed [PW-1:0]  jprod [3];
	logic signed [JW-1:0]  jp_s3 [3];
	logic signed [GW-1:0]  g0_s3 [3];
	logic signed [GW-1:0]  g0_s4 [3];
	logic signed [JW-1:0]  j_s4;
	logic v_s1, v_s2, v_s3, v_s4;
	logic adv;

	assign pt[0][0] = x0; assign pt[0][1] = x1; assign pt[0][2] = x2; assign pt[0][3] = x3;
	assign pt[1][0] = y0; assign pt[1][1] = y1; assign pt[1][2] = y2; assign pt[1][3] = y3;
	assign pt[2][0] = z0; assign pt[2][1] = z1; assign pt[2][2] = z2; assign pt[2][3] = z3;

	// The whole pipeline advances together whenever its last stage can drain.
	assign adv      = !v_s4 || q_ready;
	assign in_ready = adv;
	assign q_valid  = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_comb begin
		cof_c[0][0] = cross2(e_s1[1][1], e_s1[2][2], e_s1[1][2], e_s1[2][1]);
		cof_c[0][1] = cross2(e_s1[1][2], e_s1[2][0], e_s1[1][0], e_s1[2][2]);
		cof_c[0][2] = cross2(e_s1[1][0], e_s1[2][1], e_s1[1][1], e_s1[2][0]);
		cof_c[1][0] = cross2(e_s1[0][2], e_s1[2][1], e_s1[0][1], e_s1[2][2]);
		cof_c[1][1] = cross2(e_s1[0][0], e_s1[2][2], e_s1[2][0], e_s1[0][2]);
		cof_c[1][2] = cross2(e_s1[0][1], e_s1[2][0], e_s1[0][0], e_s1[2][1]);
		cof_c[2][0] = cross2(e_s1[0][1], e_s1[1][2], e_s1[0][2], e_s1[1][1]);
		cof_c[2][1] = cross2(e_s1[1][0], e_s1[0][2], e_s1[0][0], e_s1[1][2]);
		cof_c[2][2] = cross2(e_s1[0][0], e_s1[1][1], e_s1[1][0], e_s1[0][1]);
	end

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			jprod[a] = e1_s2[a] * cof_s2[a][0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int a = 0; a < 3; a++) begin
				for (int i = 0; i < 3; i++) begin
					e_s1[a][i] <= EDW'(pt[a][i+1]) - EDW'(pt[a][0]);
					cof_s2[a][i] <= cof_c[a][i];
					cof_s3[a][i] <= cof_s2[a][i];
					cof_s4[a][i] <= cof_s3[a][i];
				end
				e1_s2[a] <= e_s1[a][0];
				jp_s3[a] <= JW'(jprod[a]);
				g0_s3[a] <= -(GW'(cof_s2[a][0]) + GW'(cof_s2[a][1]) + GW'(cof_s2[a][2]));
				g0_s4[a] <= g0_s3[a];
			end
			j_s4 <= jp_s3[0] + jp_s3[1] + jp_s3[2];
		end
	end

	always_comb begin
		q_data = '0;
		for (int a = 0; a < 3; a++) begin
			for (int b = 0; b < 3; b++) begin
				q_data[(a*3+b)*GW +: GW] = GW'(cof_s4[a][b]);
			end
			q_data[(9+a)*GW +: GW] = g0_s4[a];
		end
		q_data[12*GW +: JW] = j_s4;
	end

endmodule

// ----- design/tsg_fifo.sv -----
// ----------------------------------------------------------------------------
// tsg_fifo
// Short register queue that decouples the pipeline from the divider.
// ----------------------------------------------------------------------------
module tsg_fifo #(
	parameter int WIDTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);
	import tsg_pkg::*;

	localparam int PTRW = $clog2(QDEPTH);
	localparam int CNTW = $clog2(QDEPTH + 1);

	logic [WIDTH-1:0] mem_q [QDEPTH];
	logic [PTRW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNTW-1:0]  count_q;
	logic             do_wr, do_rd;

	assign wr_ready = count_q != CNTW'(QDEPTH);
	assign rd_valid = count_q != '0;
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTRW'(QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTRW'(QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ----- design/tsg_back.sv -----
// ----------------------------------------------------------------------------
// tsg_back
// Three radix-2 dividers that turn the queued cofactors into node gradients.
// ----------------------------------------------------------------------------
module tsg_back #(
	parameter int COORD_WIDTH = tsg_pkg::COORD_WIDTH_DEF,
	localparam int EW = tsg_pkg::entry_w(COORD_WIDTH)
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                q_valid,
	output logic                                q_ready,
	input  logic [EW-1:0]                       q_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tsg_pkg::NODE_W-1:0]          node,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_y,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_z,
	output logic signed [tsg_pkg::JAC_W-1:0]    jacobian,
	output logic                                singular,
	output logic                                last
);
	import tsg_pkg::*;

	localparam int GW   = gval_w(COORD_WIDTH);
	localparam int JW   = jint_w(COORD_WIDTH);
	localparam int PRE  = GRAD_W - FRAC_SHIFT;
	localparam int CNTW = $clog2(GRAD_W);
	localparam logic [CNTW-1:0] ITER_LAST = CNTW'(GRAD_W - 1);

	// Saturate a 32-bit quotient magnitude to a signed Q16.16 result.
	function automatic logic [GRAD_W-1:0] sat_q(
		input logic [GRAD_W-1:0] q,
		input logic              ovf,
		input logic              neg
	);
		logic [GRAD_W-1:0] pmax;
		logic [GRAD_W-1:0] nmin;
		pmax = {1'b0, {(GRAD_W-1){1'b1}}};
		nmin = {1'b1, {(GRAD_W-1){1'b0}}};
		if (ovf) begin
			return neg ? nmin : pmax;
		end else if (neg) begin
			return q[GRAD_W-1] ? nmin : -q;
		end
		return q[GRAD_W-1] ? pmax : q;
	endfunction

	bk_state_t state_q, state_d;
	logic [CNTW-1:0]   cnt_q;
	logic [NODE_W-1:0] node_q, load_node;
	logic              load, step, pop;

	logic signed [GW-1:0] cval [3][4];
	logic signed [JW-1:0] jval;
	logic signed [63:0]   j64;
	logic [JW-1:0]        jmag;
	logic                 jneg, jzero;
	logic signed [GW-1:0] csel [3];
	logic [GW-1:0]        cmag [3];
	logic                 covf [3];

	logic [JW-1:0]     d_q;
	logic [JW-1:0]     r_q [3];
	logic [GRAD_W-1:0] n_q [3];
	logic [GRAD_W-1:0] qv_q [3];
	logic              neg_q [3];
	logic              ovf_q [3];
	logic [JW:0]       rs [3];
	logic              qbit [3];
	logic [GRAD_W-1:0] gres [3];

	// Head of the queue: node 0 sums first, then the cofactor columns.
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			cval[a][0] = q_data[(9+a)*GW +: GW];
			for (int b = 0; b < 3; b++) begin
				cval[a][b+1] = q_data[(a*3+b)*GW +: GW];
			end
		end
	end

	assign jval  = q_data[12*GW +: JW];
	assign j64   = 64'(jval);
	assign jneg  = jval[JW-1];
	assign jzero = jval == '0;
	assign jmag  = jneg ? JW'(-jval) : JW'(jval);

	assign load_node = (state_q == BK_OUT) ? node_q + 1'b1 : '0;

	always_comb begin
		for (int a = 0; a < 3; a++) begin
			csel[a] = cval[a][load_node];
			cmag[a] = csel[a][GW-1] ? GW'(-csel[a]) : GW'(csel[a]);
			// Quotient would need more than 32 bits.
			covf[a] = (JW+PRE)'(cmag[a]) >= {jmag, PRE'(0)};
			rs[a]   = {r_q[a], n_q[a][GRAD_W-1]};
			qbit[a] = rs[a] >= {1'b0, d_q};
			gres[a] = jzero ? '0 : sat_q(qv_q[a], ovf_q[a], neg_q[a]);
		end
	end

	always_comb begin
		state_d   = state_q;
		load      = 1'b0;
		step      = 1'b0;
		pop       = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			BK_IDLE: begin
				if (q_valid) begin
					load    = 1'b1;
					state_d = BK_DIV;
				end
			end
			BK_DIV: begin
				step = 1'b1;
				if (cnt_q == ITER_LAST) begin
					state_d = BK_OUT;
				end
			end
			BK_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (node_q == NODE_LAST) begin
						pop     = 1'b1;
						state_d = BK_IDLE;
					end else begin
						load    = 1'b1;
						state_d = BK_DIV;
					end
				end
			end
			default: begin
				state_d = BK_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			cnt_q   <= '0;
			node_q  <= '0;
		end else begin
			state_q <= state_d;
			if (load) begin
				cnt_q  <= '0;
				node_q <= load_node;
			end else if (step) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			d_q <= jmag;
		end
		for (int a = 0; a < 3; a++) begin
			if (load) begin
				r_q[a]   <= JW'(cmag[a] >> PRE);
				n_q[a]   <= {cmag[a][PRE-1:0], FRAC_SHIFT'(0)};
				qv_q[a]  <= '0;
				neg_q[a] <= csel[a][GW-1] ^ jneg;
				ovf_q[a] <= covf[a];
			end else if (step) begin
				r_q[a]  <= qbit[a] ? JW'(rs[a] - {1'b0, d_q}) : JW'(rs[a]);
				n_q[a]  <= {n_q[a][GRAD_W-2:0], 1'b0};
				qv_q[a] <= {qv_q[a][GRAD_W-2:0], qbit[a]};
			end
		end
	end

	assign q_ready  = pop;
	assign node     = node_q;
	assign last     = node_q == NODE_LAST;
	assign singular = jzero;
	assign jacobian = j64[JAC_W-1:0];
	assign grad_x   = gres[0];
	assign grad_y   = gres[1];
	assign grad_z   = gres[2];

endmodule

// ----- design/tetra4_shape_gradient.sv -----
// ----------------------------------------------------------------------------
// tetra4_shape_gradient
// Shape-function gradients and Jacobian of a linear four-node tetrahedron.
// ----------------------------------------------------------------------------
// Usage: one input transaction on in_valid/in_ready carries the twelve corner
// coordinates (signed Q8.8). It produces four output transactions on
// out_valid/out_ready, node 0 to 3 in order, the last with last set. Each
// carries the node's gradient (Q16.16, saturated), the determinant (Q24) and
// the singular flag, which forces the gradients to zero.
// An input passes the four pipeline stages and the queue write; then each
// node in turn is loaded into the dividers and divided before it is
// presented, node 0 first.
// The pace is set by the radix-2 dividers, one quotient bit per cycle over
// 32 bits, with x, y and z handled in three parallel lanes.
// The front pipeline and a two-entry queue keep taking new tetrahedra while
// the dividers work, so in_ready stays high until the queue is full and the front's last stage holds a tetrahedron.
// Reset (arst_n low) empties the pipeline and queue and idles the dividers.
// A stalled receiver holds the current result steady; the dividers wait, and
// the front fills and then drops in_ready.
`include "assert_macros.svh"

module tetra4_shape_gradient #(
	parameter int COORD_WIDTH = tsg_pkg::COORD_WIDTH_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_WIDTH-1:0]       x0,
	input  logic signed [COORD_WIDTH-1:0]       x1,
	input  logic signed [COORD_WIDTH-1:0]       x2,
	input  logic signed [COORD_WIDTH-1:0]       x3,
	input  logic signed [COORD_WIDTH-1:0]       y0,
	input  logic signed [COORD_WIDTH-1:0]       y1,
	input  logic signed [COORD_WIDTH-1:0]       y2,
	input  logic signed [COORD_WIDTH-1:0]       y3,
	input  logic signed [COORD_WIDTH-1:0]       z0,
	input  logic signed [COORD_WIDTH-1:0]       z1,
	input  logic signed [COORD_WIDTH-1:0]       z2,
	input  logic signed [COORD_WIDTH-1:0]       z3,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [tsg_pkg::NODE_W-1:0]          node,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_x,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_y,
	output logic signed [tsg_pkg::GRAD_W-1:0]   grad_z,
	output logic signed [tsg_pkg::JAC_W-1:0]    jacobian,
	output logic                                singular,
	output logic                                last
);
	import tsg_pkg::*;

	localparam int EW = entry_w(COORD_WIDTH);

	logic          fq_valid, fq_ready;
	logic [EW-1:0] fq_data;
	logic          bq_valid, bq_ready;
	logic [EW-1:0] bq_data;

	// Front: edge vectors, cofactors and determinant.
	tsg_front #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.x0(x0), .x1(x1), .x2(x2), .x3(x3),
		.y0(y0), .y1(y1), .y2(y2), .y3(y3),
		.z0(z0), .z1(z1), .z2(z2), .z3(z3),
		.q_valid  (fq_valid),
		.q_ready  (fq_ready),
		.q_data   (fq_data)
	);

	// Queue between the pipeline and the dividers.
	tsg_fifo #(
		.WIDTH(EW)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_data  (fq_data),
		.rd_valid (bq_valid),
		.rd_ready (bq_ready),
		.rd_data  (bq_data)
	);

	// Back: per-node division and the result channel.
	tsg_back #(
		.COORD_WIDTH(COORD_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (bq_valid),
		.q_ready   (bq_ready),
		.q_data    (bq_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.node      (node),
		.grad_x    (grad_x),
		.grad_y    (grad_y),
		.grad_z    (grad_z),
		.jacobian  (jacobian),
		.singular  (singular),
		.last      (last)
	);

	// The closing result of a run always belongs to node 3.
	`ASSERT_IMPLY(a_last_is_node3, clk, arst_n, out_valid && last, node == NODE_LAST)
	// A singular element never reports a nonzero gradient.
	`ASSERT_IMPLY(a_sing_zero, clk, arst_n, out_valid && singular, grad_x == 0 && grad_y == 0 && grad_z == 0)
	// After a non-final result is taken, the next node follows.
	`ASSERT_NEXT(a_node_seq, clk, arst_n, out_valid && out_ready && !last, node == $past(node) + 2'd1)

endmodule
